// ===== hdl/lfu_vs_pkg.sv =====
// Shared types and constants for the LFU victim selector.
`timescale 1ns / 1ps

package lfu_vs_pkg;

	// Cache geometry and counter size
	localparam int SETS       = 2048;
	localparam int WAYS       = 16;
	localparam int COUNT_BITS = 16;

	// Port field widths
	localparam int SET_W = 11;
	localparam int WAY_W = 4;

	// Derived sizes
	localparam int ROW_AW   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_AW   = $clog2(WAYS);
	localparam int GRP_SIZE = 4;
	localparam int GROUPS   = (WAYS + GRP_SIZE - 1) / GRP_SIZE;

	// Opcode values
	localparam logic OP_VICTIM = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// One memory row holds every counter of one set
	typedef logic [COUNT_BITS-1:0] ctr_t;
	typedef logic [WAYS-1:0][COUNT_BITS-1:0] row_t;

	localparam ctr_t CTR_MAX = '1;
	localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(SETS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_REDUCE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clr_wr;    // write a zero row at the clear pointer
		logic accept;    // capture a beat and start the row read
		logic upd_wr;    // write back the modified row
		logic tree_ld;   // load the group minimum stage
		logic out_ld;    // load the final victim way
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;  // clear pointer at the last row
		logic is_update; // captured beat is a counter update
	} dp_sts_t;

endpackage

// ===== hdl/lfu_victim_select_top.sv =====
// LFU victim selector: 2048 sets x 16 ways of 16-bit use counters.
// Update beat: row read, then modify and write back; no result.
// Victim beat: row read, group minimum, final minimum; busy stays high after accept,
// and done pulses with the result in the first cycle busy is low.
// Reset: a clear sweep writes zero to every row, one per cycle,
// with busy high throughout. The receiver cannot stall results.
`timescale 1ns / 1ps

module lfu_victim_select_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [lfu_vs_pkg::SET_W-1:0] set_index,
	input  logic [lfu_vs_pkg::WAY_W-1:0] way_index,
	input  logic                         hit,
	input  logic                         is_writeback,
	output logic                         done,
	output logic [lfu_vs_pkg::WAY_W-1:0] victim_way
);

	lfu_vs_pkg::dp_cmd_t cmd;
	lfu_vs_pkg::dp_sts_t sts;

	// Sequence the clear sweep and each beat
	lfu_vs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Counter store, update logic and min tree
	lfu_vs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.set_index    (set_index),
		.way_index    (way_index),
		.hit          (hit),
		.is_writeback (is_writeback),
		.victim_way   (victim_way)
	);

endmodule

// ===== hdl/lfu_vs_ctrl.sv =====
// Controller state machine for the LFU victim selector.
`timescale 1ns / 1ps

module lfu_vs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lfu_vs_pkg::dp_sts_t sts,
	output lfu_vs_pkg::dp_cmd_t cmd,
	output logic                busy,
	output logic                done
);

	lfu_vs_pkg::state_t state_q;
	lfu_vs_pkg::state_t state_nxt;
	logic               done_q;

	// State register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_vs_pkg::ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == lfu_vs_pkg::ST_REDUCE);
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lfu_vs_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_nxt = lfu_vs_pkg::ST_IDLE;
			end
			lfu_vs_pkg::ST_IDLE: begin
				if (start) state_nxt = lfu_vs_pkg::ST_LOOK;
			end
			lfu_vs_pkg::ST_LOOK: begin
				if (sts.is_update) state_nxt = lfu_vs_pkg::ST_IDLE;
				else               state_nxt = lfu_vs_pkg::ST_REDUCE;
			end
			lfu_vs_pkg::ST_REDUCE: begin
				state_nxt = lfu_vs_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = lfu_vs_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			lfu_vs_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			lfu_vs_pkg::ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			lfu_vs_pkg::ST_LOOK: begin
				cmd.upd_wr  = sts.is_update;
				cmd.tree_ld = !sts.is_update;
			end
			lfu_vs_pkg::ST_REDUCE: begin
				cmd.out_ld = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign done = done_q;

endmodule

// ===== hdl/lfu_vs_dp.sv =====
// Datapath for the LFU victim selector: counter memory, update and min tree.
`timescale 1ns / 1ps

module lfu_vs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lfu_vs_pkg::dp_cmd_t               cmd,
	output lfu_vs_pkg::dp_sts_t               sts,
	input  logic                              opcode,
	input  logic [lfu_vs_pkg::SET_W-1:0]      set_index,
	input  logic [lfu_vs_pkg::WAY_W-1:0]      way_index,
	input  logic                              hit,
	input  logic                              is_writeback,
	output logic [lfu_vs_pkg::WAY_W-1:0]      victim_way
);

	// Counter memory, one set per row
	lfu_vs_pkg::row_t mem [lfu_vs_pkg::SETS];

	logic [lfu_vs_pkg::ROW_AW-1:0] clr_cnt_q;
	logic                          op_q;
	logic [lfu_vs_pkg::SET_W-1:0]  set_q;
	logic [lfu_vs_pkg::WAY_W-1:0]  way_q;
	logic                          hit_q;
	logic                          wb_q;
	lfu_vs_pkg::row_t              rd_row_s1;
	lfu_vs_pkg::ctr_t              grp_min_s2 [lfu_vs_pkg::GROUPS];
	logic [lfu_vs_pkg::WAY_AW-1:0] grp_idx_s2 [lfu_vs_pkg::GROUPS];
	logic [lfu_vs_pkg::WAY_W-1:0]  victim_q;

	lfu_vs_pkg::ctr_t              grp_min_c [lfu_vs_pkg::GROUPS];
	logic [lfu_vs_pkg::WAY_AW-1:0] grp_idx_c [lfu_vs_pkg::GROUPS];
	lfu_vs_pkg::ctr_t              best_min_c;
	logic [lfu_vs_pkg::WAY_AW-1:0] best_idx_c;
	lfu_vs_pkg::row_t              row_c;
	lfu_vs_pkg::ctr_t              cur_c;
	logic                          set_ok;
	logic                          way_ok;
	logic                          wr_en;
	logic [lfu_vs_pkg::ROW_AW-1:0] wr_addr;
	lfu_vs_pkg::row_t              wr_data;

	// Advance the clear pointer during the post-reset sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr && clr_cnt_q != lfu_vs_pkg::ROW_LAST) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clr_last  = (clr_cnt_q == lfu_vs_pkg::ROW_LAST);
	assign sts.is_update = (op_q == lfu_vs_pkg::OP_UPDATE);

	// Hold the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= opcode;
			set_q <= set_index;
			way_q <= way_index;
			hit_q <= hit;
			wb_q  <= is_writeback;
		end
	end

	assign set_ok = (32'(set_q) < lfu_vs_pkg::SETS);
	assign way_ok = (32'(way_q) < lfu_vs_pkg::WAYS);

	// Read the addressed row
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_row_s1 <= mem[set_index[lfu_vs_pkg::ROW_AW-1:0]];
		end
	end

	// Modify one counter: clear on fill, saturating increment on plain hit, no change on writeback hit
	always_comb begin
		row_c = rd_row_s1;
		cur_c = rd_row_s1[way_q[lfu_vs_pkg::WAY_AW-1:0]];
		if (!hit_q) begin
			row_c[way_q[lfu_vs_pkg::WAY_AW-1:0]] = '0;
		end else if (!wb_q && cur_c != lfu_vs_pkg::CTR_MAX) begin
			row_c[way_q[lfu_vs_pkg::WAY_AW-1:0]] = cur_c + 1'b1;
		end
	end

	// Write port: clear sweep or counter write-back
	assign wr_en   = cmd.clr_wr || (cmd.upd_wr && set_ok && way_ok);
	assign wr_addr = cmd.clr_wr ? clr_cnt_q : set_q[lfu_vs_pkg::ROW_AW-1:0];
	assign wr_data = cmd.clr_wr ? '0 : row_c;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// First tree level: lowest-numbered minimum inside each group of ways
	always_comb begin
		for (int g = 0; g < lfu_vs_pkg::GROUPS; g++) begin
			grp_min_c[g] = rd_row_s1[lfu_vs_pkg::WAY_AW'(g * lfu_vs_pkg::GRP_SIZE)];
			grp_idx_c[g] = lfu_vs_pkg::WAY_AW'(g * lfu_vs_pkg::GRP_SIZE);
			for (int i = 1; i < lfu_vs_pkg::GRP_SIZE; i++) begin
				if ((g * lfu_vs_pkg::GRP_SIZE + i) < lfu_vs_pkg::WAYS &&
				    rd_row_s1[lfu_vs_pkg::WAY_AW'(g * lfu_vs_pkg::GRP_SIZE + i)]
				    < grp_min_c[g]) begin
					grp_min_c[g] =
						rd_row_s1[lfu_vs_pkg::WAY_AW'(g * lfu_vs_pkg::GRP_SIZE + i)];
					grp_idx_c[g] = lfu_vs_pkg::WAY_AW'(g * lfu_vs_pkg::GRP_SIZE + i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tree_ld) begin
			for (int g = 0; g < lfu_vs_pkg::GROUPS; g++) begin
				grp_min_s2[g] <= grp_min_c[g];
				grp_idx_s2[g] <= grp_idx_c[g];
			end
		end
	end

	// Second tree level: earlier group wins a tie
	always_comb begin
		best_min_c = grp_min_s2[0];
		best_idx_c = grp_idx_s2[0];
		for (int g = 1; g < lfu_vs_pkg::GROUPS; g++) begin
			if (grp_min_s2[g] < best_min_c) begin
				best_min_c = grp_min_s2[g];
				best_idx_c = grp_idx_s2[g];
			end
		end
	end

	// Load the result; a set beyond the cache answers way zero
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			victim_q <= set_ok ? lfu_vs_pkg::WAY_W'(best_idx_c) : '0;
		end
	end

	assign victim_way = victim_q;

endmodule

// ===== dv/lfu_victim_select_top_tb.sv =====
// Self-checking testbench for the LFU victim selector: directed, repeated-hit and random phases.
`timescale 1ns / 1ps

module lfu_victim_select_top_tb;

	import lfu_vs_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int RANDOM_BEATS = 700;
	localparam int SAT_HITS     = 40;  // hits on one way of the top set
	localparam int TAIL_CYCLES  = 16;

	typedef logic [SET_W-1:0] set_t;
	typedef logic [WAY_W-1:0] way_t;

	// One cache access as presented to the block
	typedef struct {
		logic op;
		set_t set;
		way_t way;
		logic hit;
		logic wb;
		bit   drain;  // hold this beat until every victim result is back
	} access_t;

	logic clk          = 1'b0;
	logic arst_n       = 1'b0;
	logic start        = 1'b0;
	logic opcode       = OP_VICTIM;
	set_t set_index    = '0;
	way_t way_index    = '0;
	logic hit          = 1'b0;
	logic is_writeback = 1'b0;
	logic busy;
	logic done;
	way_t victim_way;

	access_t pending_access[$];
	way_t    expected_victim[$];
	ctr_t    use_count[SETS*WAYS] = '{default: '0};
	int      outstanding;
	int      fail_cnt        = 0;
	int      victims_checked = 0;
	int      updates_applied = 0;
	int      saturated_hits  = 0;
	int      cycle_cnt       = 0;
	bit      drain_next;

	lfu_victim_select_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.set_index    (set_index),
		.way_index    (way_index),
		.hit          (hit),
		.is_writeback (is_writeback),
		.done         (done),
		.victim_way   (victim_way)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Lowest-numbered way holding the smallest use count in a set
	function automatic way_t least_used_way(set_t s);
		int   base;
		int   best_way;
		ctr_t best;
		if (int'(s) >= SETS)
			return '0;
		base     = int'(s) * WAYS;
		best     = use_count[base];
		best_way = 0;
		for (int w = 1; w < WAYS; w++) begin
			if (use_count[base + w] < best) begin
				best     = use_count[base + w];
				best_way = w;
			end
		end
		return way_t'(best_way);
	endfunction

	// Fold one counter update into the predicted store
	task automatic apply_update(set_t s, way_t w, logic h, logic wb);
		int idx;
		if (int'(s) >= SETS || int'(w) >= WAYS)
			return;
		idx = int'(s) * WAYS + int'(w);
		updates_applied++;
		if (h) begin
			if (!wb) begin
				if (use_count[idx] == CTR_MAX)
					saturated_hits++;
				else
					use_count[idx] = use_count[idx] + 1'b1;
			end
		end else begin
			use_count[idx] = '0;
		end
	endtask

	task automatic add_access(logic op, set_t s, way_t w, logic h, logic wb);
		access_t a;
		a.op       = op;
		a.set      = s;
		a.way      = w;
		a.hit      = h;
		a.wb       = wb;
		a.drain    = drain_next;
		drain_next = 1'b0;
		pending_access.push_back(a);
	endtask

	// Driver: present queued beats in bursts with random gaps
	int      gap_left;
	int      burst_left;
	access_t cur;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start        <= 1'b0;
			opcode       <= OP_VICTIM;
			set_index    <= '0;
			way_index    <= '0;
			hit          <= 1'b0;
			is_writeback <= 1'b0;
			gap_left     = 0;
			burst_left   = $urandom_range(1, 24);
		end else if (!start || !busy) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				start <= 1'b0;
			end else if (pending_access.size() == 0) begin
				start <= 1'b0;
			end else if (pending_access[0].drain && (start || outstanding != 0)) begin
				// hold off until the result queue has drained
				start <= 1'b0;
			end else begin
				cur = pending_access.pop_front();
				start        <= 1'b1;
				opcode       <= cur.op;
				set_index    <= cur.set;
				way_index    <= cur.way;
				hit          <= cur.hit;
				is_writeback <= cur.wb;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left = burst_left - 1;
				end
			end
		end
	end

	// Monitor: check result beats, then predict from accepted beats
	way_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_victim.size() == 0) begin
					$error("victim_way: no result expected, actual %0d", victim_way);
					fail_cnt++;
				end else begin
					want = expected_victim.pop_front();
					victims_checked++;
					if (victim_way !== want) begin
						$error("victim_way: expected %0d, actual %0d", want, victim_way);
						fail_cnt++;
					end
				end
			end
			if (start && !busy) begin
				if (opcode == OP_VICTIM)
					expected_victim.push_back(least_used_way(set_index));
				else
					apply_update(set_index, way_index, hit, is_writeback);
			end
			outstanding <= expected_victim.size();
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("lfu_victim_select_top_tb NOT OK");
			$finish;
		end
	end

	// Stimulus and end of run
	set_t set_pool[6];
	logic op;
	set_t s;

	initial begin
		drain_next      = 1'b0;

		// Directed: extremes, every operation, writeback hit and miss writeback
		add_access(OP_VICTIM, '0, '0, 1'b0, 1'b0);
		add_access(OP_VICTIM, set_t'(SETS - 1), '1, 1'b1, 1'b1);
		add_access(OP_UPDATE, '0, '0, 1'b1, 1'b0);
		add_access(OP_VICTIM, '0, '0, 1'b0, 1'b0);
		add_access(OP_UPDATE, '0, way_t'(1), 1'b1, 1'b1);
		add_access(OP_VICTIM, '0, '0, 1'b0, 1'b0);
		add_access(OP_UPDATE, '0, way_t'(1), 1'b1, 1'b0);
		add_access(OP_VICTIM, '0, '0, 1'b0, 1'b0);
		add_access(OP_UPDATE, '0, '0, 1'b0, 1'b1);
		add_access(OP_VICTIM, '0, '0, 1'b0, 1'b0);
		add_access(OP_UPDATE, '0, '1, 1'b1, 1'b0);
		add_access(OP_UPDATE, '0, '1, 1'b1, 1'b0);
		add_access(OP_UPDATE, '0, '1, 1'b0, 1'b0);
		add_access(OP_VICTIM, '0, '1, 1'b1, 1'b1);
		add_access(OP_UPDATE, set_t'(SETS - 1), '1, 1'b0, 1'b0);
		add_access(OP_VICTIM, set_t'(SETS - 1), '0, 1'b0, 1'b0);

		// Repeated hits: lift ways 0..14 of the top set to two, then hammer way 15
		drain_next = 1'b1;
		for (int w = 0; w < WAYS - 1; w++) begin
			add_access(OP_UPDATE, set_t'(SETS - 1), way_t'(w), 1'b1, 1'b0);
			add_access(OP_UPDATE, set_t'(SETS - 1), way_t'(w), 1'b1, 1'b0);
		end
		add_access(OP_VICTIM, set_t'(SETS - 1), '0, 1'b0, 1'b0);
		for (int n = 1; n <= SAT_HITS; n++) begin
			add_access(OP_UPDATE, set_t'(SETS - 1), '1, 1'b1, 1'b0);
			if (n % 16 == 0)
				add_access(OP_VICTIM, set_t'(SETS - 1), '0, 1'b0, 1'b0);
		end
		add_access(OP_VICTIM, set_t'(SETS - 1), '0, 1'b0, 1'b0);
		add_access(OP_UPDATE, set_t'(SETS - 1), '1, 1'b1, 1'b1);
		add_access(OP_UPDATE, set_t'(SETS - 1), way_t'(3), 1'b0, 1'b0);
		add_access(OP_VICTIM, set_t'(SETS - 1), '0, 1'b0, 1'b0);

		// Random: mostly a small pool of sets so counts build up and victims move
		set_pool[0] = '0;
		set_pool[1] = set_t'(SETS - 1);
		set_pool[2] = set_t'(5);
		set_pool[3] = set_t'(1024);
		set_pool[4] = set_t'($urandom);
		set_pool[5] = set_t'($urandom);
		drain_next = 1'b1;
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i % 200 == 199)
				drain_next = 1'b1;
			op = ($urandom_range(0, 99) < 35) ? OP_VICTIM : OP_UPDATE;
			s  = ($urandom_range(0, 9) == 0) ? set_t'($urandom)
			                                 : set_pool[$urandom_range(0, 5)];
			add_access(op, s, way_t'($urandom_range(0, WAYS - 1)),
			           logic'($urandom_range(0, 3) != 0), logic'($urandom_range(0, 3) == 0));
		end

		// Release reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_access.size() != 0 || start || outstanding != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d victim results over %0d counter updates (%0d hits at saturation).",
		         victims_checked, updates_applied, saturated_hits);
		$display("Phases: directed corners, repeated hits on one way of the top set, random pool traffic.");
		if (fail_cnt == 0)
			$display("lfu_victim_select_top_tb OK");
		else
			$display("lfu_victim_select_top_tb NOT OK");
		$finish;
	end

endmodule
